/* sv/rowpart_pkg.sv */
// shared types and constants for the row-aligned nonzero partitioner
// no dependencies

package rowpart_pkg;

   localparam int DEF_MAX_PARTS  = 64;
   localparam int DEF_INDEX_BITS = 32;
   localparam int DEF_COUNT_BITS = 32;

   localparam int NUM_PARTS_BITS  = 7;
   localparam int TARGET_BITS     = 32;
   localparam int CSR_INDEX_BITS  = 1;
   localparam int CSR_DATA_BITS   = 32;
   localparam int QUEUE_DEPTH     = 4;

   localparam logic [NUM_PARTS_BITS-1:0] NUM_PARTS_RESET = NUM_PARTS_BITS'(1);
   localparam logic [TARGET_BITS-1:0]    TARGET_RESET    = '0;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_NUM_PARTS  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET_NNZ = 1'b1;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_FIRST,
      KIND_SAME,
      KIND_NEWROW
   } kind_type;

   typedef struct packed {
      kind_type kind;
      logic     last;
      logic     err;
   } entry_type;

endpackage

/* sv/rowpart_fifo.sv */
// small register queue, one push and one pop per cycle
// depends on rowpart_pkg for the depth

module rowpart_fifo
   import rowpart_pkg::*;
#(
   parameter int W = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   output logic         full,
   input  logic         pop,
   output logic [W-1:0] pop_data,
   output logic         empty
);

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = PTR_BITS + 1;

   logic [W-1:0]        mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in    = push ? wr_ff + PTR_BITS'(1) : wr_ff;
      rd_in    = pop ? rd_ff + PTR_BITS'(1) : rd_ff;
      count_in = count_ff + CNT_BITS'(push) - CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

/* sv/rowpart_rspq.sv */
// result queue, takes up to two results per cycle and gives one
// depends on rowpart_pkg for the depth

module rowpart_rspq
   import rowpart_pkg::*;
#(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push0,
   input  logic [W-1:0] push0_data,
   input  logic         push1,
   input  logic [W-1:0] push1_data,
   output logic         room2,
   input  logic         pop,
   output logic [W-1:0] pop_data,
   output logic         valid
);

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = PTR_BITS + 1;

   logic [W-1:0]        mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ff, wr_in, rd_ff, rd_in, wr_next;
   logic [CNT_BITS-1:0] count_ff, count_in;

   assign room2    = (count_ff <= CNT_BITS'(QUEUE_DEPTH - 2));
   assign valid    = (count_ff != '0);
   assign pop_data = mem_ff[rd_ff];
   assign wr_next  = wr_ff + PTR_BITS'(1);

   always_comb begin
      wr_in    = wr_ff + PTR_BITS'(push0) + PTR_BITS'(push1);
      rd_in    = pop ? rd_ff + PTR_BITS'(1) : rd_ff;
      count_in = count_ff + CNT_BITS'(push0) + CNT_BITS'(push1) - CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push0) begin
         mem_ff[wr_ff] <= push0_data;
      end
      if (push1) begin
         mem_ff[wr_next] <= push1_data;
      end
   end

endmodule

/* sv/rowpart_front.sv */
// front end: compares each row index with the previous one and classifies it
// depends on rowpart_pkg for the entry type

module rowpart_front
   import rowpart_pkg::*;
#(
   parameter int INDEX_BITS = DEF_INDEX_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [INDEX_BITS-1:0] row,
   input  logic                  last,
   output entry_type             entry
);

   logic [INDEX_BITS-1:0] prev_ff, prev_in;
   logic                  seen_ff, seen_in;
   logic                  err_ff, err_in;
   kind_type              kind;

   always_comb begin
      prev_in = prev_ff;
      seen_in = seen_ff;
      err_in  = err_ff;
      kind    = KIND_NONE;
      if (!err_ff) begin
         if (!seen_ff) begin
            kind    = KIND_FIRST;
            seen_in = 1'b1;
            prev_in = row;
         end else if (row == prev_ff) begin
            kind = KIND_SAME;
         end else if (row > prev_ff) begin
            kind    = KIND_NEWROW;
            prev_in = row;
         end else begin
            err_in = 1'b1;
         end
      end
      entry.kind = kind;
      entry.last = last;
      entry.err  = err_in;
      if (last) begin
         prev_in = '0;
         seen_in = 1'b0;
         err_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         seen_ff <= 1'b0;
         err_ff  <= 1'b0;
      end else if (accept) begin
         prev_ff <= prev_in;
         seen_ff <= seen_in;
         err_ff  <= err_in;
      end
   end

endmodule

/* sv/rowpart_back.sv */
// back end: keeps the open partition's counts, closes and flushes partitions
// depends on rowpart_pkg for the entry type and register widths

module rowpart_back
   import rowpart_pkg::*;
#(
   parameter int MAX_PARTS  = DEF_MAX_PARTS,
   parameter int COUNT_BITS = DEF_COUNT_BITS,
   parameter int PART_BITS  = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1,
   parameter int RES_BITS   = PART_BITS + 2 * COUNT_BITS + 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      pop,
   input  entry_type                 entry,
   input  logic [NUM_PARTS_BITS-1:0] num_parts,
   input  logic [TARGET_BITS-1:0]    target_nnz,
   output logic                      push0,
   output logic [RES_BITS-1:0]       push0_data,
   output logic                      push1,
   output logic [RES_BITS-1:0]       push1_data
);

   localparam int LIM_BITS = (PART_BITS + 1 > NUM_PARTS_BITS) ? PART_BITS + 1 : NUM_PARTS_BITS;
   localparam int CMP_BITS = (COUNT_BITS > TARGET_BITS) ? COUNT_BITS : TARGET_BITS;

   logic [PART_BITS-1:0]  part_ff, part_in, part_upd;
   logic [COUNT_BITS-1:0] nnz_ff, nnz_in, nnz_upd, nnz_inc;
   logic [COUNT_BITS-1:0] rows_ff, rows_in, rows_upd, rows_inc;
   logic [LIM_BITS-1:0]   np_ext, limit, part_next;
   logic                  below_target, at_limit, close;
   logic [RES_BITS-1:0]   res_close, res_final;

   always_comb begin
      np_ext = LIM_BITS'(num_parts);
      if (np_ext == '0) begin
         limit = LIM_BITS'(1);
      end else if (np_ext > LIM_BITS'(MAX_PARTS)) begin
         limit = LIM_BITS'(MAX_PARTS);
      end else begin
         limit = np_ext;
      end
      part_next    = LIM_BITS'(part_ff) + LIM_BITS'(1);
      at_limit     = (part_next >= limit);
      below_target = (CMP_BITS'(nnz_ff) < CMP_BITS'(target_nnz));
      nnz_inc      = (nnz_ff == '1) ? nnz_ff : nnz_ff + COUNT_BITS'(1);
      rows_inc     = (rows_ff == '1) ? rows_ff : rows_ff + COUNT_BITS'(1);

      part_upd = part_ff;
      nnz_upd  = nnz_ff;
      rows_upd = rows_ff;
      close    = 1'b0;
      case (entry.kind)
         KIND_FIRST: begin
            part_upd = '0;
            nnz_upd  = COUNT_BITS'(1);
            rows_upd = COUNT_BITS'(1);
         end
         KIND_SAME: begin
            nnz_upd = nnz_inc;
         end
         KIND_NEWROW: begin
            if (below_target || at_limit) begin
               nnz_upd  = nnz_inc;
               rows_upd = rows_inc;
            end else begin
               close    = 1'b1;
               part_upd = part_next[PART_BITS-1:0];
               nnz_upd  = COUNT_BITS'(1);
               rows_upd = COUNT_BITS'(1);
            end
         end
         default: begin
            part_upd = part_ff;
         end
      endcase

      // fields from low to high: part, nnz, rows, unsorted, final
      res_close = {1'b0, 1'b0, rows_ff, nnz_ff, part_ff};
      res_final = {1'b1, entry.err, rows_upd, nnz_upd, part_upd};

      push0      = pop && (close || entry.last);
      push0_data = close ? res_close : res_final;
      push1      = pop && close && entry.last;
      push1_data = res_final;

      part_in = entry.last ? '0 : part_upd;
      nnz_in  = entry.last ? '0 : nnz_upd;
      rows_in = entry.last ? '0 : rows_upd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         part_ff <= '0;
         nnz_ff  <= '0;
         rows_ff <= '0;
      end else if (pop) begin
         part_ff <= part_in;
         nnz_ff  <= nnz_in;
         rows_ff <= rows_in;
      end
   end

endmodule

/* sv/row_aligned_nonzero_partitioner.sv */
// Row-aligned nonzero partitioner. Takes one sorted row index per cycle and
// reports each closed partition (id, nonzero count, row count) plus a final
// report on the item marked tlast. An item passes the classifier in the front
// in its accept cycle, waits in a four-word queue, and is counted by the back;
// results go through a four-word result queue. Sustained rate is one item per
// clock while the rsp side keeps up; a stalled rsp side stops the back once the
// result queue lacks room for two words, fills the input queue and then drops
// req_tready. Results of an item that closes a partition and is also last take
// two rsp words. Depends on rowpart_pkg, rowpart_front, rowpart_fifo,
// rowpart_back, rowpart_rspq.

module row_aligned_nonzero_partitioner
   import rowpart_pkg::*;
#(
   parameter int MAX_PARTS  = DEF_MAX_PARTS,
   parameter int INDEX_BITS = DEF_INDEX_BITS,
   parameter int COUNT_BITS = DEF_COUNT_BITS,
   parameter int PART_BITS  = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1,
   parameter int REQ_BITS   = ((INDEX_BITS + 7) / 8) * 8,
   parameter int RSP_BITS   = ((PART_BITS + 2 * COUNT_BITS + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   // input stream
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_BITS-1:0]       req_tdata,  // row_index
   input  logic                      req_tlast,  // is_last
   // result stream
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_BITS-1:0]       rsp_tdata,  // part_id, nnz_count, row_count
   output logic                      rsp_tuser,  // unsorted
   output logic                      rsp_tlast,  // final_res
   // register writes
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int ENTRY_BITS = $bits(entry_type);
   localparam int RES_BITS   = PART_BITS + 2 * COUNT_BITS + 2;

   logic [NUM_PARTS_BITS-1:0] num_parts_ff;
   logic [TARGET_BITS-1:0]    target_nnz_ff;

   logic                  req_accept;
   entry_type             front_entry, back_entry;
   logic [ENTRY_BITS-1:0] inq_out;
   logic                  inq_full, inq_empty, back_pop;
   logic                  push0, push1, room2, rspq_valid, rsp_pop;
   logic [RES_BITS-1:0]   push0_data, push1_data, rsp_word;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_parts_ff  <= NUM_PARTS_RESET;
         target_nnz_ff <= TARGET_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_NUM_PARTS:  num_parts_ff  <= csr_data[NUM_PARTS_BITS-1:0];
            CSR_TARGET_NNZ: target_nnz_ff <= csr_data[TARGET_BITS-1:0];
            default:        num_parts_ff  <= num_parts_ff;
         endcase
      end
   end

   assign req_tready = !inq_full;
   assign req_accept = req_tvalid && req_tready;

   rowpart_front #(
      .INDEX_BITS (INDEX_BITS)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (req_accept),
      .row    (req_tdata[INDEX_BITS-1:0]),
      .last   (req_tlast),
      .entry  (front_entry)
   );

   rowpart_fifo #(
      .W (ENTRY_BITS)
   ) u_inq (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (front_entry),
      .full      (inq_full),
      .pop       (back_pop),
      .pop_data  (inq_out),
      .empty     (inq_empty)
   );

   assign back_entry = entry_type'(inq_out);
   assign back_pop   = !inq_empty && room2;

   rowpart_back #(
      .MAX_PARTS  (MAX_PARTS),
      .COUNT_BITS (COUNT_BITS),
      .PART_BITS  (PART_BITS),
      .RES_BITS   (RES_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop        (back_pop),
      .entry      (back_entry),
      .num_parts  (num_parts_ff),
      .target_nnz (target_nnz_ff),
      .push0      (push0),
      .push0_data (push0_data),
      .push1      (push1),
      .push1_data (push1_data)
   );

   rowpart_rspq #(
      .W (RES_BITS)
   ) u_rspq (
      .clock      (clock),
      .reset      (reset),
      .push0      (push0),
      .push0_data (push0_data),
      .push1      (push1),
      .push1_data (push1_data),
      .room2      (room2),
      .pop        (rsp_pop),
      .pop_data   (rsp_word),
      .valid      (rspq_valid)
   );

   assign rsp_tvalid = rspq_valid;
   assign rsp_pop    = rspq_valid && rsp_tready;
   assign rsp_tdata  = RSP_BITS'(rsp_word[PART_BITS+2*COUNT_BITS-1:0]);
   assign rsp_tuser  = rsp_word[RES_BITS-2];
   assign rsp_tlast  = rsp_word[RES_BITS-1];

endmodule

/* dv/partition_report_check.sv */
// predicts and checks the partition reports of row_aligned_nonzero_partitioner
// watches the req, rsp and csr channels; depends on rowpart_pkg

module partition_report_check
   import rowpart_pkg::*;
#(
   parameter int REQ_BITS = 32,
   parameter int RSP_BITS = 72
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [REQ_BITS-1:0]       req_tdata,
   input  logic                      req_tlast,
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [RSP_BITS-1:0]       rsp_tdata,
   input  logic                      rsp_tuser,
   input  logic                      rsp_tlast,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   output int                        outstanding,
   output int                        fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PART_BITS = $clog2(DEF_MAX_PARTS);
   localparam int CNT_BITS  = DEF_COUNT_BITS;

   typedef struct packed {
      logic [PART_BITS-1:0] part_id;
      logic [CNT_BITS-1:0]  nnz_count;
      logic [CNT_BITS-1:0]  row_count;
      logic                 unsorted;
      logic                 is_final;
   } part_report_type;

   part_report_type expected_reports[$];

   logic [NUM_PARTS_BITS-1:0] num_parts;
   logic [TARGET_BITS-1:0]    target_nnz;
   logic [DEF_INDEX_BITS-1:0] prev_row;
   logic [PART_BITS-1:0]      part_index;
   logic [CNT_BITS-1:0]       open_nnz;
   logic [CNT_BITS-1:0]       open_rows;
   logic                      seen_first;
   logic                      error_seen;
   int                        errors = 0;

   assign fail_count = errors;

   task automatic flag(input string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      errors++;
   endtask

   task automatic compare_field(input string name, input logic [CNT_BITS-1:0] got,
                                input logic [CNT_BITS-1:0] want);
      if (got !== want)
         flag($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
   endtask

   function automatic logic [CNT_BITS-1:0] sat_bump(input logic [CNT_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   task automatic clear_tensor();
      prev_row   = '0;
      part_index = '0;
      open_nnz   = '0;
      open_rows  = '0;
      seen_first = 1'b0;
      error_seen = 1'b0;
   endtask

   task automatic log_report(input logic fin);
      expected_reports.push_back('{part_index, open_nnz, open_rows, fin & error_seen, fin});
   endtask

   task automatic predict_partitions(input logic [DEF_INDEX_BITS-1:0] row, input logic last);
      int limit;
      limit = (num_parts == 0) ? 1 :
              (int'(num_parts) > DEF_MAX_PARTS) ? DEF_MAX_PARTS : int'(num_parts);
      if (!error_seen) begin
         if (!seen_first) begin
            seen_first = 1'b1;
            part_index = '0;
            open_nnz   = 1;
            open_rows  = 1;
            prev_row   = row;
         end else if (row == prev_row) begin
            open_nnz = sat_bump(open_nnz);
         end else if (row > prev_row) begin
            if (open_nnz < target_nnz || int'(part_index) + 1 >= limit) begin
               open_nnz  = sat_bump(open_nnz);
               open_rows = sat_bump(open_rows);
            end else begin
               log_report(1'b0);
               part_index = part_index + 1'b1;
               open_nnz   = 1;
               open_rows  = 1;
            end
            prev_row = row;
         end else begin
            error_seen = 1'b1;
         end
      end
      if (last) begin
         log_report(1'b1);
         clear_tensor();
      end
   endtask

   always @(posedge clock) begin
      part_report_type got;
      part_report_type want;
      if (reset) begin
         num_parts  = NUM_PARTS_RESET;
         target_nnz = TARGET_RESET;
         clear_tensor();
         expected_reports.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.part_id   = rsp_tdata[PART_BITS-1:0];
            got.nnz_count = rsp_tdata[PART_BITS +: CNT_BITS];
            got.row_count = rsp_tdata[PART_BITS + CNT_BITS +: CNT_BITS];
            got.unsorted  = rsp_tuser;
            got.is_final  = rsp_tlast;
            if (expected_reports.size() == 0) begin
               flag($sformatf("unexpected rsp word for partition %0d", got.part_id));
            end else begin
               want = expected_reports.pop_front();
               compare_field("part_id", CNT_BITS'(got.part_id), CNT_BITS'(want.part_id));
               compare_field("nnz_count", got.nnz_count, want.nnz_count);
               compare_field("row_count", got.row_count, want.row_count);
               compare_field("unsorted", CNT_BITS'(got.unsorted), CNT_BITS'(want.unsorted));
               compare_field("final_res", CNT_BITS'(got.is_final), CNT_BITS'(want.is_final));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_NUM_PARTS:  num_parts  = csr_data[NUM_PARTS_BITS-1:0];
               CSR_TARGET_NNZ: target_nnz = csr_data[TARGET_BITS-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            predict_partitions(req_tdata[DEF_INDEX_BITS-1:0], req_tlast);
      end
      outstanding <= expected_reports.size();
   end

endmodule

/* dv/testbench.sv */
// stimulus and verdict for row_aligned_nonzero_partitioner: directed tensors,
// then random, mostly sorted tensors over several register settings with random idling
// depends on rowpart_pkg, the block itself and partition_report_check

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rowpart_pkg::*;

   localparam int PART_BITS       = $clog2(DEF_MAX_PARTS);
   localparam int REQ_BITS        = ((DEF_INDEX_BITS + 7) / 8) * 8;
   localparam int RSP_BITS        = ((PART_BITS + 2 * DEF_COUNT_BITS + 7) / 8) * 8;
   localparam int NUM_PHASES      = 10;
   localparam int ITEMS_PER_PHASE = 200;
   localparam int DRAIN_CYCLES    = 16;
   localparam int STALL_LIMIT     = 2000;
   localparam int DIRECTED_COUNT  = 17;

   // first/equal/close, last partition reached, close plus flush, single word,
   // decreasing with ignored words, decreasing on the last word
   localparam logic [31:0] DIRECTED_ROWS [DIRECTED_COUNT] = '{
      32'd0, 32'd0, 32'd1, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      32'd7, 32'd7, 32'd9,
      32'd5,
      32'd10, 32'd3, 32'd12, 32'd2,
      32'd10, 32'd11, 32'd4
   };
   localparam bit DIRECTED_LAST [DIRECTED_COUNT] = '{
      0, 0, 0, 0, 0, 1,
      0, 0, 1,
      1,
      0, 0, 0, 1,
      0, 0, 1
   };

   localparam logic [NUM_PARTS_BITS-1:0] FIXED_PARTS [5] = '{7'd0, 7'd127, 7'd64, 7'd1, 7'd2};
   localparam logic [31:0] FIXED_TARGET [5] = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd5, 32'd0};

   logic                      clock;
   logic                      reset       = 1'b1;
   logic                      req_tvalid  = 1'b0;
   logic                      req_tready;
   logic [REQ_BITS-1:0]       req_tdata   = '0;   // row_index
   logic                      req_tlast   = 1'b0; // is_last
   logic                      rsp_tvalid;
   logic                      rsp_tready  = 1'b0;
   logic [RSP_BITS-1:0]       rsp_tdata;          // part_id, nnz_count, row_count
   logic                      rsp_tuser;          // unsorted
   logic                      rsp_tlast;          // final_res
   logic                      csr_valid   = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index   = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data    = '0;

   int          outstanding;
   int          fail_count;
   int          idle_cycles   = 0;
   int unsigned send_idle_pct = 30;
   int unsigned take_idle_pct = 30;

   row_aligned_nonzero_partitioner dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   partition_report_check #(
      .REQ_BITS (REQ_BITS),
      .RSP_BITS (RSP_BITS)
   ) report_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("row_aligned_nonzero_partitioner regression: fail");
         $finish;
      end
   end

   // result side back-pressure
   initial begin
      @(posedge clock);
      forever begin
         if ($urandom_range(99) < take_idle_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(17, 1)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(8, 1)) @(posedge clock);
      end
   end

   task automatic send_word(input logic [31:0] row, input logic last);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(17, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= row;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] sel, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= sel;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // sorted run with random repeats and steps; corrupt puts at most one decreasing word in
   task automatic send_tensor(input int unsigned len, input bit corrupt);
      logic [32:0] next_row;
      logic [31:0] row;
      logic [31:0] step;
      int unsigned pick;
      int unsigned bad_at;
      bad_at = $urandom_range(len - 1);
      case ($urandom_range(3))
         0:       row = '0;
         1:       row = $urandom_range(100);
         2:       row = $urandom;
         default: row = 32'hFFFF_FFFF - $urandom_range(60);
      endcase
      for (int i = 0; i < len; i++) begin
         if (i > 0) begin
            pick = $urandom_range(19);
            if (pick < 8)
               step = 0;
            else if (pick < 16)
               step = $urandom_range(3, 1);
            else if (pick < 19)
               step = $urandom_range(1000, 1);
            else
               step = $urandom;
            next_row = {1'b0, row} + {1'b0, step};
            if (!next_row[32])
               row = next_row[31:0];
         end
         if (corrupt && i == bad_at && row != 0)
            send_word($urandom_range(row - 1), i == len - 1);
         else
            send_word(row, i == len - 1);
      end
   endtask

   initial begin
      logic [NUM_PARTS_BITS-1:0] parts;
      logic [31:0]               target;
      int unsigned               sent;
      int unsigned               len;
      wait (!reset);
      @(posedge clock);
      write_reg(CSR_NUM_PARTS, 32'd3);
      write_reg(CSR_TARGET_NNZ, 32'd2);
      for (int i = 0; i < DIRECTED_COUNT; i++)
         send_word(DIRECTED_ROWS[i], DIRECTED_LAST[i]);

      for (int p = 0; p < NUM_PHASES; p++) begin
         settle();
         if (p < 5) begin
            parts  = FIXED_PARTS[p];
            target = FIXED_TARGET[p];
         end else begin
            parts = ($urandom_range(3) == 0) ? NUM_PARTS_BITS'($urandom_range(127)) :
                                               NUM_PARTS_BITS'($urandom_range(12));
            case ($urandom_range(5))
               0:       target = '0;
               1:       target = $urandom;
               default: target = $urandom_range(8, 1);
            endcase
         end
         write_reg(CSR_NUM_PARTS, 32'(parts));
         write_reg(CSR_TARGET_NNZ, target);
         if (p >= NUM_PHASES - 2) begin
            send_idle_pct = 0;
            take_idle_pct = 0;
         end else begin
            send_idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(50, 10);
            take_idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(50, 10);
         end
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(80, 25) : $urandom_range(24, 1);
            send_tensor(len, $urandom_range(9) == 0);
            sent += len;
         end
      end

      settle();
      if (fail_count == 0)
         $display("row_aligned_nonzero_partitioner regression: pass");
      else
         $display("row_aligned_nonzero_partitioner regression: fail");
      $finish;
   end

endmodule
